// ===== rtl/tilt_pkg.sv =====
// tilt_pkg: widths, register codes, result layout and the arc table shared by the
// tilt-angle pipeline and its cells
// no dependencies
`timescale 1ns / 1ps

package tilt_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int GUARD_BITS   = 24 - SAMPLE_WIDTH;

  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int ONE_G_W     = 15;
  localparam logic [ONE_G_W-1:0] ONE_G_RESET = 15'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_G    = 2'd3;

  // corrected component, scaled component, sum of squares and its root
  localparam int CORR_W     = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 2;
  localparam int G_W        = CORR_W + GUARD_BITS;
  localparam int SQ_W       = 2 * CORR_W;
  localparam int N_W        = SQ_W + 2 * GUARD_BITS;
  localparam int SQRT_STEPS = N_W / 2;
  localparam int SQ_IDX_W   = $clog2(SQRT_STEPS);
  localparam int SH_W       = $clog2(N_W);
  localparam int SQRT_TOP   = N_W - 2;

  // cordic lanes, angle accumulator in 1/32768 degree
  localparam int LANE_W       = G_W + 3;
  localparam int ACC_W        = 26;
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_IDX_W = $clog2(CORDIC_STEPS);
  localparam int ANGLE_SHIFT  = 8;
  localparam logic signed [ACC_W-1:0] DEG180      = 26'sd5898240;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS  = 26'sd128;
  localparam logic signed [ACC_W-1:0] ROLL_LIMIT  = 26'sd23040;
  localparam logic signed [ACC_W-1:0] PITCH_LIMIT = 26'sd11520;

  localparam logic signed [ACC_W-1:0] ARC_TABLE [CORDIC_STEPS] = '{
    26'sd1474560, 26'sd870484, 26'sd459940, 26'sd233473, 26'sd117189,
    26'sd58652,   26'sd29333,  26'sd14667,  26'sd7334,   26'sd3667,
    26'sd1833,    26'sd917,    26'sd458,    26'sd229,    26'sd115,
    26'sd57,      26'sd29,     26'sd14,     26'sd7,      26'sd4
  };

  localparam int ROLL_W     = 16;
  localparam int PITCH_W    = 15;
  localparam int CORR_OUT_W = 18;

  localparam int IN_FIELDS_W  = 3 * SAMPLE_WIDTH;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ROLL_W + PITCH_W + 3 * CORR_OUT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic signed [CORR_W-1:0] x;
    logic signed [CORR_W-1:0] y;
    logic signed [CORR_W-1:0] z;
  } corr_t;

  typedef struct packed {
    logic [N_W-1:0] rem;
    logic [N_W-1:0] root;
    corr_t          corr;
  } sqrt_t;

  typedef struct packed {
    logic signed [LANE_W-1:0] x;
    logic signed [LANE_W-1:0] y;
    logic signed [ACC_W-1:0]  acc;
    logic                     zero;
  } lane_t;

  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    corr_t corr;
  } cordic_t;

  // first member sits in the top bits
  typedef struct packed {
    logic [CORR_OUT_W-1:0] cz;
    logic [CORR_OUT_W-1:0] cy;
    logic [CORR_OUT_W-1:0] cx;
    logic [PITCH_W-1:0]    pitch;
    logic [ROLL_W-1:0]     roll;
  } result_t;

endpackage

// ===== rtl/tilt_sqrt_cell.sv =====
// tilt_sqrt_cell: one registered step of the digit-by-digit square root,
// settling one root bit and carrying the corrected sample along
// depends on tilt_pkg
`timescale 1ns / 1ps

module tilt_sqrt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [tilt_pkg::SQ_IDX_W-1:0] step,
  input  logic                          in_valid,
  input  tilt_pkg::sqrt_t               in_data,
  output logic                          out_valid,
  output tilt_pkg::sqrt_t               out_data
);
  import tilt_pkg::*;

  logic [SH_W-1:0] sh;
  logic [N_W-1:0]  bitv;
  logic [N_W:0]    trial;
  sqrt_t           data_next;

  always_comb begin
    sh    = SH_W'(SQRT_TOP) - SH_W'({step, 1'b0});
    bitv  = N_W'(1) << sh;
    trial = {1'b0, in_data.root} + {1'b0, bitv};
    data_next      = in_data;
    if ({1'b0, in_data.rem} >= trial) begin
      data_next.rem  = in_data.rem - trial[N_W-1:0];
      data_next.root = (in_data.root >> 1) + bitv;
    end else begin
      data_next.root = in_data.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== rtl/tilt_cordic_cell.sv =====
// tilt_cordic_cell: one registered cordic vectoring iteration for the roll and
// pitch lanes side by side
// depends on tilt_pkg
`timescale 1ns / 1ps

module tilt_cordic_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic [tilt_pkg::CORDIC_IDX_W-1:0] step,
  input  logic                              in_valid,
  input  tilt_pkg::cordic_t                 in_data,
  output logic                              out_valid,
  output tilt_pkg::cordic_t                 out_data
);
  import tilt_pkg::*;

  cordic_t data_next;

  function automatic lane_t rotate(input lane_t l, input logic [CORDIC_IDX_W-1:0] i);
    lane_t                    r;
    logic signed [LANE_W-1:0] dx;
    logic signed [LANE_W-1:0] dy;
    dx = l.y >>> i;
    dy = l.x >>> i;
    r  = l;
    if (!l.y[LANE_W-1]) begin
      r.x   = l.x + dx;
      r.y   = l.y - dy;
      r.acc = l.acc + ARC_TABLE[i];
    end else begin
      r.x   = l.x - dx;
      r.y   = l.y + dy;
      r.acc = l.acc - ARC_TABLE[i];
    end
    return r;
  endfunction

  always_comb begin
    data_next       = in_data;
    data_next.roll  = rotate(in_data.roll, step);
    data_next.pitch = rotate(in_data.pitch, step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== rtl/accel_tilt_angles.sv =====
// accel_tilt_angles: roll and pitch from one offset-corrected accelerometer sample,
// through a square-root cell chain and a cordic cell chain with an output skid stage
// depends on tilt_pkg, tilt_sqrt_cell, tilt_cordic_cell
//
//  channel  | direction | handshake                    | contents
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | sample_x, sample_y, sample_z
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | roll, pitch, corrected x/y/z
//  cfg      | in        | cfg_we                       | offsets and one_g by index
//
// one sample per cycle while the skid stage is empty; from request to result: three entry stages,
// 26 square-root cells, a setup stage, 20 cordic cells and the output register
// rst clears every stage valid and loads the register defaults
// s_axis_tready is a registered flag: low only while the skid stage holds a result
`timescale 1ns / 1ps

module accel_tilt_angles (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // sample_x, sample_y, sample_z
  input  logic [tilt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // roll_angle, pitch_angle, corrected_x, corrected_y, corrected_z, zero pad
  output logic [tilt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [tilt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tilt_pkg::CFG_W-1:0]       cfg_data
);
  import tilt_pkg::*;

  logic signed [CFG_W-1:0] offset_x;
  logic signed [CFG_W-1:0] offset_y;
  logic signed [CFG_W-1:0] offset_z;
  logic [ONE_G_W-1:0]      one_g;

  logic                          en;
  logic signed [SAMPLE_WIDTH-1:0] sx;
  logic signed [SAMPLE_WIDTH-1:0] sy;
  logic signed [SAMPLE_WIDTH-1:0] sz;
  logic signed [ONE_G_W:0]       og;
  corr_t                         corr_next;

  logic           v0;
  corr_t          c0;
  logic           v1;
  corr_t          c1;
  logic [SQ_W-1:0] sqy;
  logic [SQ_W-1:0] sqz;
  logic [SQ_W-1:0] sq_sum;
  logic           v2;
  sqrt_t          s2;

  logic           sqrt_v [SQRT_STEPS];
  sqrt_t          sqrt_d [SQRT_STEPS];

  logic                      v3;
  cordic_t                   s3;
  cordic_t                   setup_next;
  logic [SQRT_STEPS-1:0]     mag;
  logic signed [LANE_W-1:0]  gx;
  logic signed [LANE_W-1:0]  gy;
  logic signed [LANE_W-1:0]  gz;
  logic signed [LANE_W-1:0]  magl;

  logic           cordic_v [CORDIC_STEPS];
  cordic_t        cordic_d [CORDIC_STEPS];

  logic           push;
  logic           pop;
  logic           out_valid;
  logic           skid_valid;
  result_t        res_next;
  result_t        out_res;
  result_t        skid_res;
  logic signed [ACC_W-1:0] roll_a;
  logic signed [ACC_W-1:0] pitch_a;

  function automatic lane_t lane_init(input logic signed [LANE_W-1:0] b,
                                      input logic signed [LANE_W-1:0] a);
    lane_t l;
    l.zero = (a == '0) && (b == '0);
    if (a[LANE_W-1]) begin
      l.acc = b[LANE_W-1] ? -DEG180 : DEG180;
      l.x   = -a;
      l.y   = -b;
    end else begin
      l.acc = '0;
      l.x   = a;
      l.y   = b;
    end
    return l;
  endfunction

  function automatic logic signed [ACC_W-1:0] lane_angle(input lane_t l,
                                                         input logic signed [ACC_W-1:0] lim);
    logic signed [ACC_W-1:0] r;
    r = (l.acc + ROUND_BIAS) >>> ANGLE_SHIFT;
    if (r > lim) begin
      r = lim;
    end
    if (r < -lim) begin
      r = -lim;
    end
    if (l.zero) begin
      r = '0;
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
      one_g    <= ONE_G_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        REG_OFFSET_Z: offset_z <= cfg_data;
        REG_ONE_G:    one_g    <= cfg_data[ONE_G_W-1:0];
        default:      one_g    <= one_g;
      endcase
    end
  end

  assign en            = !skid_valid;
  assign s_axis_tready = en;

  // offset correction, with one_g added to z
  always_comb begin
    sx = s_axis_tdata[SAMPLE_WIDTH-1:0];
    sy = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    sz = s_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
    og = {1'b0, one_g};
    corr_next.x = CORR_W'(sx) - CORR_W'(offset_x);
    corr_next.y = CORR_W'(sy) - CORR_W'(offset_y);
    corr_next.z = CORR_W'(sz) - CORR_W'(offset_z) + CORR_W'(og);
  end

  assign sq_sum = sqy + sqz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s_axis_tvalid) begin
      c0 <= corr_next;
    end
    if (en && v0) begin
      c1  <= c0;
      sqy <= SQ_W'(c0.y * c0.y);
      sqz <= SQ_W'(c0.z * c0.z);
    end
    if (en && v1) begin
      s2.rem  <= N_W'(sq_sum) << (2 * GUARD_BITS);
      s2.root <= '0;
      s2.corr <= c1;
    end
  end

  // square-root chain
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    if (g == 0) begin : g_first
      tilt_sqrt_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .step     (SQ_IDX_W'(g)),
        .in_valid (v2),
        .in_data  (s2),
        .out_valid(sqrt_v[g]),
        .out_data (sqrt_d[g])
      );
    end else begin : g_next
      tilt_sqrt_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .step     (SQ_IDX_W'(g)),
        .in_valid (sqrt_v[g-1]),
        .in_data  (sqrt_d[g-1]),
        .out_valid(sqrt_v[g]),
        .out_data (sqrt_d[g])
      );
    end
  end

  // quadrant setup for both vectoring lanes
  always_comb begin
    mag  = sqrt_d[SQRT_STEPS-1].root[SQRT_STEPS-1:0];
    magl = LANE_W'(mag);
    gx   = LANE_W'(sqrt_d[SQRT_STEPS-1].corr.x) <<< GUARD_BITS;
    gy   = LANE_W'(sqrt_d[SQRT_STEPS-1].corr.y) <<< GUARD_BITS;
    gz   = LANE_W'(sqrt_d[SQRT_STEPS-1].corr.z) <<< GUARD_BITS;
    setup_next.roll  = lane_init(gy, gz);
    setup_next.pitch = lane_init(-gx, magl);
    setup_next.corr  = sqrt_d[SQRT_STEPS-1].corr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= sqrt_v[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en && sqrt_v[SQRT_STEPS-1]) begin
      s3 <= setup_next;
    end
  end

  // cordic chain
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    if (g == 0) begin : g_first
      tilt_cordic_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .step     (CORDIC_IDX_W'(g)),
        .in_valid (v3),
        .in_data  (s3),
        .out_valid(cordic_v[g]),
        .out_data (cordic_d[g])
      );
    end else begin : g_next
      tilt_cordic_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .step     (CORDIC_IDX_W'(g)),
        .in_valid (cordic_v[g-1]),
        .in_data  (cordic_d[g-1]),
        .out_valid(cordic_v[g]),
        .out_data (cordic_d[g])
      );
    end
  end

  // rounding, clamping and result packing
  always_comb begin
    roll_a         = lane_angle(cordic_d[CORDIC_STEPS-1].roll, ROLL_LIMIT);
    pitch_a        = lane_angle(cordic_d[CORDIC_STEPS-1].pitch, PITCH_LIMIT);
    res_next.roll  = roll_a[ROLL_W-1:0];
    res_next.pitch = pitch_a[PITCH_W-1:0];
    res_next.cx    = cordic_d[CORDIC_STEPS-1].corr.x[CORR_OUT_W-1:0];
    res_next.cy    = cordic_d[CORDIC_STEPS-1].corr.y[CORR_OUT_W-1:0];
    res_next.cz    = cordic_d[CORDIC_STEPS-1].corr.z[CORR_OUT_W-1:0];
  end

  // output register and skid stage
  assign push = en && cordic_v[CORDIC_STEPS-1];
  assign pop  = out_valid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_res <= skid_res;
    end else if (push && (pop || !out_valid)) begin
      out_res <= res_next;
    end
    if (push && out_valid && !pop) begin
      skid_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_res);

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output register is empty");

  a_skid_refills: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_axis_tready) |=> (out_valid && !skid_valid))
    else $error("skid result not moved into the output register");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_res.roll) <= 16'sd23040 &&
                   $signed(out_res.roll) >= -16'sd23040))
    else $error("roll angle outside its clamp range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_res.pitch) <= 15'sd11520 &&
                   $signed(out_res.pitch) >= -15'sd11520))
    else $error("pitch angle outside its clamp range");

endmodule
